// ===== rtl/nfve_pkg.sv =====
// ----------------------------------------------------------------------------
// nfve_pkg
// Shared constants, sentence type codes and the result record for the NMEA
// field value extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfve_pkg;

   // Default build options
   localparam int MAX_FRAC_DIGITS_DEF  = 5;
   localparam int FIELD_COUNT_BITS_DEF = 6;

   // Output field widths
   localparam int CHAR_W  = 8;
   localparam int TYPE_W  = 3;
   localparam int INDEX_W = 6;
   localparam int VALUE_W = 32;
   localparam int FRAC_W  = 3;

   // Characters with a meaning in the sentence syntax
   localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_POINT  = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

   // Sentence type codes
   localparam logic [TYPE_W-1:0] TYPE_OTHER = 3'd0;
   localparam logic [TYPE_W-1:0] TYPE_RMC   = 3'd1;
   localparam logic [TYPE_W-1:0] TYPE_GGA   = 3'd2;
   localparam logic [TYPE_W-1:0] TYPE_GSA   = 3'd3;
   localparam logic [TYPE_W-1:0] TYPE_GSV   = 3'd4;
   localparam logic [TYPE_W-1:0] TYPE_VTG   = 3'd5;

   // Address field tails, three characters
   localparam logic [3*CHAR_W-1:0] TAG_RMC = "RMC";
   localparam logic [3*CHAR_W-1:0] TAG_GGA = "GGA";
   localparam logic [3*CHAR_W-1:0] TAG_GSA = "GSA";
   localparam logic [3*CHAR_W-1:0] TAG_GSV = "GSV";
   localparam logic [3*CHAR_W-1:0] TAG_VTG = "VTG";

   // One finished field
   typedef struct packed {
      logic [TYPE_W-1:0]         sentence_type;
      logic [INDEX_W-1:0]        field_index;
      logic                      present;
      logic signed [VALUE_W-1:0] field_value;
      logic [FRAC_W-1:0]         frac_digits;
      logic [CHAR_W-1:0]         first_char;
      logic                      sentence_end;
      logic [CHAR_W-1:0]         body_xor;
   } nfve_result_type;

   // Map the last three address characters to a sentence type
   function automatic logic [TYPE_W-1:0] decode_type(input logic [3*CHAR_W-1:0] tail);
      logic [TYPE_W-1:0] code;
      code = TYPE_OTHER;
      if (tail == TAG_RMC) code = TYPE_RMC;
      else if (tail == TAG_GGA) code = TYPE_GGA;
      else if (tail == TAG_GSA) code = TYPE_GSA;
      else if (tail == TAG_GSV) code = TYPE_GSV;
      else if (tail == TAG_VTG) code = TYPE_VTG;
      return code;
   endfunction

endpackage

// ===== rtl/nfve_req_if.sv =====
// ----------------------------------------------------------------------------
// nfve_req_if
// Character channel: one sentence byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nfve_req_if;
   logic                          valid;
   logic                          ready;
   logic [nfve_pkg::CHAR_W-1:0]   char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

// ===== rtl/nfve_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nfve_rsp_if
// Field result channel: one finished field per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nfve_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [nfve_pkg::TYPE_W-1:0]          sentence_type;
   logic [nfve_pkg::INDEX_W-1:0]         field_index;
   logic                                 present;
   logic signed [nfve_pkg::VALUE_W-1:0]  field_value;
   logic [nfve_pkg::FRAC_W-1:0]          frac_digits;
   logic [nfve_pkg::CHAR_W-1:0]          first_char;
   logic                                 sentence_end;
   logic [nfve_pkg::CHAR_W-1:0]          body_xor;

   modport source (output valid, output sentence_type, output field_index,
                   output present, output field_value, output frac_digits,
                   output first_char, output sentence_end, output body_xor,
                   input ready);
   modport sink   (input valid, input sentence_type, input field_index,
                   input present, input field_value, input frac_digits,
                   input first_char, input sentence_end, input body_xor,
                   output ready);
endinterface

// ===== rtl/nmea_field_value_extractor.sv =====
// ----------------------------------------------------------------------------
// nmea_field_value_extractor
// Path: the byte that closes a field passes the input register, then its result
// is written into the result register, which drives the output.
// Throughput: one byte per cycle, held while a result waits for a busy slot.
// Reset: synchronous, clears the parser state and both register valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_field_value_extractor #(
   parameter int MAX_FRAC_DIGITS  = nfve_pkg::MAX_FRAC_DIGITS_DEF,
   parameter int FIELD_COUNT_BITS = nfve_pkg::FIELD_COUNT_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   nfve_req_if.sink     req_chan,
   nfve_rsp_if.source   rsp_chan
);

   logic                              in_valid_ff;
   logic [nfve_pkg::CHAR_W-1:0]       in_char_ff;
   logic                              out_valid_ff;
   nfve_pkg::nfve_result_type         out_data_ff;

   logic                              core_emit;
   nfve_pkg::nfve_result_type         core_result;
   logic                              out_free;
   logic                              advance;

   // Input item moves on unless it closes a field and the result slot is busy
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!core_emit || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   nfve_field_core #(
      .MAX_FRAC_DIGITS  (MAX_FRAC_DIGITS),
      .FIELD_COUNT_BITS (FIELD_COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_byte (in_char_ff),
      .emit      (core_emit),
      .result    (core_result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_char_ff <= req_chan.char_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && core_emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_emit) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.sentence_type = out_data_ff.sentence_type;
   assign rsp_chan.field_index   = out_data_ff.field_index;
   assign rsp_chan.present       = out_data_ff.present;
   assign rsp_chan.field_value   = out_data_ff.field_value;
   assign rsp_chan.frac_digits   = out_data_ff.frac_digits;
   assign rsp_chan.first_char    = out_data_ff.first_char;
   assign rsp_chan.sentence_end  = out_data_ff.sentence_end;
   assign rsp_chan.body_xor      = out_data_ff.body_xor;

endmodule

// ===== rtl/nfve_field_core.sv =====
// ----------------------------------------------------------------------------
// nfve_field_core
// Sentence and field parser state. Given one character, computes whether it
// finishes a field and the field's result; updates state when stepped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfve_field_core #(
   parameter int MAX_FRAC_DIGITS  = nfve_pkg::MAX_FRAC_DIGITS_DEF,
   parameter int FIELD_COUNT_BITS = nfve_pkg::FIELD_COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [nfve_pkg::CHAR_W-1:0]   char_byte,
   output logic                          emit,
   output nfve_pkg::nfve_result_type     result
);

   localparam int FRAC_BITS = (MAX_FRAC_DIGITS > 0) ? $clog2(MAX_FRAC_DIGITS + 1) : 1;
   localparam logic [FIELD_COUNT_BITS-1:0] COUNT_MAX = {FIELD_COUNT_BITS{1'b1}};
   localparam logic [FRAC_BITS-1:0] FRAC_MAX = FRAC_BITS'(MAX_FRAC_DIGITS);

   // Sentence state
   logic                                in_sentence_ff, in_sentence_in;
   logic [FIELD_COUNT_BITS-1:0]         comma_count_ff, comma_count_in;
   logic [3*nfve_pkg::CHAR_W-1:0]       last_three_ff, last_three_in;
   logic [nfve_pkg::TYPE_W-1:0]         type_code_ff, type_code_in;
   logic [nfve_pkg::CHAR_W-1:0]         running_xor_ff, running_xor_in;

   // Field state
   logic [nfve_pkg::VALUE_W-1:0]        accumulator_ff, accumulator_in;
   logic [FRAC_BITS-1:0]                frac_count_ff, frac_count_in;
   logic                                after_point_ff, after_point_in;
   logic                                negative_ff, negative_in;
   logic                                bad_char_ff, bad_char_in;
   logic [nfve_pkg::CHAR_W-1:0]         field_first_ff, field_first_in;
   logic                                nonempty_ff, nonempty_in;

   logic                                is_dollar, is_end, is_comma, is_digit;
   logic [nfve_pkg::CHAR_W-1:0]         xor_next;
   logic [nfve_pkg::VALUE_W-1:0]        acc_times_ten;
   logic [nfve_pkg::TYPE_W-1:0]         type_emit;
   logic [nfve_pkg::VALUE_W-1:0]        value_emit;
   logic [FIELD_COUNT_BITS+nfve_pkg::INDEX_W-1:0] index_wide;
   logic [FRAC_BITS+nfve_pkg::FRAC_W-1:0]         frac_wide;

   // Character classes
   assign is_dollar = (char_byte == nfve_pkg::CHAR_DOLLAR);
   assign is_end    = (char_byte == nfve_pkg::CHAR_STAR) ||
                      (char_byte < nfve_pkg::CHAR_SPACE) ||
                      (char_byte > nfve_pkg::CHAR_LOW_Z);
   assign is_comma  = (char_byte == nfve_pkg::CHAR_COMMA);
   assign is_digit  = (char_byte >= nfve_pkg::CHAR_ZERO) &&
                      (char_byte <= nfve_pkg::CHAR_NINE);

   assign xor_next      = running_xor_ff ^ char_byte;
   // x*10 + digit as shift-add
   assign acc_times_ten = (accumulator_ff << 3) + (accumulator_ff << 1) +
                          nfve_pkg::VALUE_W'(char_byte - nfve_pkg::CHAR_ZERO);

   // Result of the field that this character closes
   assign emit = in_sentence_ff && !is_dollar && (is_end || is_comma);

   assign type_emit  = (is_comma && comma_count_ff == '0) ?
                       nfve_pkg::decode_type(last_three_ff) : type_code_ff;
   assign value_emit = bad_char_ff ? '0 :
                       (negative_ff ? (~accumulator_ff + 1'b1) : accumulator_ff);
   assign index_wide = {{nfve_pkg::INDEX_W{1'b0}}, comma_count_ff};
   assign frac_wide  = {{nfve_pkg::FRAC_W{1'b0}}, (bad_char_ff ? '0 : frac_count_ff)};

   always_comb begin
      result.sentence_type = type_emit;
      result.field_index   = index_wide[nfve_pkg::INDEX_W-1:0];
      result.present       = is_end ? 1'b1 : nonempty_ff;
      result.field_value   = value_emit;
      result.frac_digits   = frac_wide[nfve_pkg::FRAC_W-1:0];
      result.first_char    = field_first_ff;
      result.sentence_end  = is_end;
      result.body_xor      = is_end ? running_xor_ff : xor_next;
   end

   // Next state
   always_comb begin
      in_sentence_in = in_sentence_ff;
      comma_count_in = comma_count_ff;
      last_three_in  = last_three_ff;
      type_code_in   = type_code_ff;
      running_xor_in = running_xor_ff;
      accumulator_in = accumulator_ff;
      frac_count_in  = frac_count_ff;
      after_point_in = after_point_ff;
      negative_in    = negative_ff;
      bad_char_in    = bad_char_ff;
      field_first_in = field_first_ff;
      nonempty_in    = nonempty_ff;

      if (is_dollar || (in_sentence_ff && (is_end || is_comma))) begin
         accumulator_in = '0;
         frac_count_in  = '0;
         after_point_in = 1'b0;
         negative_in    = 1'b0;
         bad_char_in    = 1'b0;
         field_first_in = '0;
         nonempty_in    = 1'b0;
      end

      if (is_dollar) begin
         in_sentence_in = 1'b1;
         comma_count_in = '0;
         last_three_in  = '0;
         type_code_in   = nfve_pkg::TYPE_OTHER;
         running_xor_in = '0;
      end else if (in_sentence_ff) begin
         if (is_end) begin
            in_sentence_in = 1'b0;
         end else begin
            running_xor_in = xor_next;
            if (is_comma) begin
               type_code_in = type_emit;
               if (comma_count_ff != COUNT_MAX) comma_count_in = comma_count_ff + 1'b1;
            end else begin
               last_three_in = {last_three_ff[2*nfve_pkg::CHAR_W-1:0], char_byte};
               nonempty_in   = 1'b1;
               if (!nonempty_ff) field_first_in = char_byte;
               // Value digits, sign and decimal point
               if (!bad_char_ff) begin
                  if (char_byte == nfve_pkg::CHAR_MINUS) begin
                     if (!nonempty_ff) negative_in = 1'b1;
                     else bad_char_in = 1'b1;
                  end else if (char_byte == nfve_pkg::CHAR_POINT) begin
                     if (after_point_ff) bad_char_in = 1'b1;
                     else after_point_in = 1'b1;
                  end else if (is_digit) begin
                     if (!after_point_ff) begin
                        accumulator_in = acc_times_ten;
                     end else if (frac_count_ff < FRAC_MAX) begin
                        accumulator_in = acc_times_ten;
                        frac_count_in  = frac_count_ff + 1'b1;
                     end
                  end else begin
                     bad_char_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         comma_count_ff <= '0;
         last_three_ff  <= '0;
         type_code_ff   <= nfve_pkg::TYPE_OTHER;
         running_xor_ff <= '0;
         accumulator_ff <= '0;
         frac_count_ff  <= '0;
         after_point_ff <= 1'b0;
         negative_ff    <= 1'b0;
         bad_char_ff    <= 1'b0;
         field_first_ff <= '0;
         nonempty_ff    <= 1'b0;
      end else if (step) begin
         in_sentence_ff <= in_sentence_in;
         comma_count_ff <= comma_count_in;
         last_three_ff  <= last_three_in;
         type_code_ff   <= type_code_in;
         running_xor_ff <= running_xor_in;
         accumulator_ff <= accumulator_in;
         frac_count_ff  <= frac_count_in;
         after_point_ff <= after_point_in;
         negative_ff    <= negative_in;
         bad_char_ff    <= bad_char_in;
         field_first_ff <= field_first_in;
         nonempty_ff    <= nonempty_in;
      end
   end

   // A '$' always opens a clean sentence
   a_dollar_opens: assert property (@(posedge clock) disable iff (reset)
      step && is_dollar |=> in_sentence_ff && comma_count_ff == '0 && running_xor_ff == '0)
      else $error("sentence start did not clear state");

   // Fields only close inside a sentence
   a_emit_in_sentence: assert property (@(posedge clock) disable iff (reset)
      emit |-> in_sentence_ff)
      else $error("field result outside a sentence");

   // An ending character leaves the sentence
   a_end_leaves: assert property (@(posedge clock) disable iff (reset)
      step && emit && result.sentence_end |=> !in_sentence_ff && !nonempty_ff)
      else $error("sentence end did not close the sentence");

endmodule
